>>> hdl/date_difference_assert.svh
// date_difference_assert.svh
// assertion macros shared by the date difference checker
// expects signals clk and rst in the scope of use
`ifndef DATE_DIFFERENCE_ASSERT_SVH
`define DATE_DIFFERENCE_ASSERT_SVH

// clocking and reset qualifier for every check
`define DD_ASSERT_CLK @(posedge clk) disable iff (rst)

// labelled concurrent check with a failure message
`define DD_ASSERT(lbl, prop, msg) \
  lbl: assert property (`DD_ASSERT_CLK (prop)) else $error(msg);

`endif

>>> hdl/dd_pkg.sv
// dd_pkg.sv
// constants and helper functions for the date difference block
// no dependencies
`timescale 1ns / 1ps

package dd_pkg;

  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int DAYNUM_W = 23;
  localparam int FULL_YEARS_W = 15;

  // highest year taken as is, larger years saturate here
  localparam int unsigned YEAR_MAX = 9999;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned DAYS_PER_LEAP_YEAR = 366;
  localparam int unsigned CENTURY = 100;
  localparam int unsigned QUAD_CENTURY = 400;

  // floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
  localparam int DIV100_IN_W = YEAR_W + 1;
  localparam int DIV100_OUT_W = 8;
  localparam int unsigned DIV100_MUL = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_PROD_W = DIV100_IN_W + 13;

  localparam int DOY_W = 9;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  typedef logic [YEAR_W-1:0] year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0] day_t;
  typedef logic [DAYNUM_W-1:0] daynum_t;
  typedef logic signed [FULL_YEARS_W-1:0] full_years_t;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
  } date_t;

  function automatic year_t clamp_year(input year_t y);
    year_t r;
    r = y;
    if (32'(y) > YEAR_MAX) begin
      r = YEAR_W'(YEAR_MAX);
    end
    return r;
  endfunction

  function automatic logic [DIV100_OUT_W-1:0] div100(input logic [DIV100_IN_W-1:0] x);
    logic [DIV100_PROD_W-1:0] p;
    p = DIV100_PROD_W'(x) * DIV100_PROD_W'(DIV100_MUL);
    return DIV100_OUT_W'(p >> DIV100_SHIFT);
  endfunction

  // days before the first of month m; months past december see the full year
  function automatic logic [DOY_W-1:0] days_before_month(input month_t m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = DOY_W'(DAYS_PER_YEAR);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/dd_day_number.sv
// dd_day_number.sv
// closed-form day count of one date from the first day of year zero
// uses dd_pkg
`timescale 1ns / 1ps

module dd_day_number (
  input  dd_pkg::date_t   date,
  output dd_pkg::daynum_t day_number
);

  logic [dd_pkg::DIV100_IN_W-1:0] y_ext;
  logic [dd_pkg::DIV100_IN_W-1:0] y_p3;
  logic [dd_pkg::DIV100_IN_W-1:0] y_p99;
  logic [dd_pkg::DIV100_IN_W-1:0] y_p399;
  logic [dd_pkg::DIV100_OUT_W-1:0] cent_floor;
  logic [dd_pkg::DIV100_OUT_W-1:0] cent_ceil;
  logic [dd_pkg::DIV100_OUT_W-1:0] quad_cent;
  logic leap;
  logic leap_add;

  assign y_ext  = dd_pkg::DIV100_IN_W'(date.year);
  assign y_p3   = y_ext + dd_pkg::DIV100_IN_W'(3);
  assign y_p99  = y_ext + dd_pkg::DIV100_IN_W'(dd_pkg::CENTURY - 1);
  assign y_p399 = y_ext + dd_pkg::DIV100_IN_W'(dd_pkg::QUAD_CENTURY - 1);

  assign cent_floor = dd_pkg::div100(y_ext);
  assign cent_ceil  = dd_pkg::div100(y_p99);
  assign quad_cent  = dd_pkg::div100(y_p399 >> 2);

  // multiple of 100 when floor and ceiling of y/100 agree
  assign leap = (date.year[1:0] == 2'b00) &&
                ((cent_floor != cent_ceil) || (cent_floor[1:0] == 2'b00));
  assign leap_add = leap && (date.month > dd_pkg::MONTH_FEB);

  always_comb begin
    day_number = dd_pkg::DAYNUM_W'(date.year) * dd_pkg::DAYNUM_W'(dd_pkg::DAYS_PER_YEAR)
               + dd_pkg::DAYNUM_W'(y_p3 >> 2)
               - dd_pkg::DAYNUM_W'(cent_ceil)
               + dd_pkg::DAYNUM_W'(quad_cent)
               + dd_pkg::DAYNUM_W'(dd_pkg::days_before_month(date.month))
               + dd_pkg::DAYNUM_W'(leap_add)
               + dd_pkg::DAYNUM_W'(date.day);
  end

endmodule

>>> hdl/dd_year_count.sv
// dd_year_count.sv
// completed years between two dates, anniversary on month and day
// uses dd_pkg
`timescale 1ns / 1ps

module dd_year_count (
  input  dd_pkg::date_t       from_date,
  input  dd_pkg::date_t       to_date,
  output dd_pkg::full_years_t full_years
);

  logic anniv_reached;

  assign anniv_reached = (to_date.month > from_date.month) ||
                         ((to_date.month == from_date.month) &&
                          (to_date.day >= from_date.day));

  always_comb begin
    full_years = dd_pkg::FULL_YEARS_W'(to_date.year)
               - dd_pkg::FULL_YEARS_W'(from_date.year)
               - dd_pkg::FULL_YEARS_W'(1)
               + dd_pkg::FULL_YEARS_W'(anniv_reached);
  end

endmodule

>>> hdl/date_difference.sv
// date_difference.sv
// top level: input register, day count and year count logic, result register
// uses dd_pkg, dd_day_number, dd_year_count
`timescale 1ns / 1ps

//  channel | handshake                   | word
//  --------+-----------------------------+-------------------------------------------
//  dates   | dates_valid / dates_stall   | from_year/month/day, to_year/month/day
//  result  | result_valid / result_stall | day_difference, full_years
//
//  one date pair per cycle unless stalled; input register, then result register
//  the rate is set by the single pass of closed-form logic between the registers
//  rst clears both valid flags; payload registers are not reset
//  dates_stall rises only while both registers hold words and result_stall is high

module date_difference (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 dates_valid,
  output logic                                 dates_stall,
  input  logic [dd_pkg::YEAR_W-1:0]            from_year,
  input  logic [dd_pkg::MONTH_W-1:0]           from_month,
  input  logic [dd_pkg::DAY_W-1:0]             from_day,
  input  logic [dd_pkg::YEAR_W-1:0]            to_year,
  input  logic [dd_pkg::MONTH_W-1:0]           to_month,
  input  logic [dd_pkg::DAY_W-1:0]             to_day,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [dd_pkg::DAYNUM_W-1:0]   day_difference,
  output logic signed [dd_pkg::FULL_YEARS_W-1:0] full_years
);

  // input register
  logic          in_vld;
  dd_pkg::date_t in_from;
  dd_pkg::date_t in_to;

  logic dates_take;
  logic res_load;

  // combinational single pass
  dd_pkg::date_t       from_clamped;
  dd_pkg::date_t       to_clamped;
  dd_pkg::daynum_t     from_dn;
  dd_pkg::daynum_t     to_dn;
  dd_pkg::full_years_t years_calc;

  // result register can load when empty or when its word is leaving
  assign res_load    = !result_valid || !result_stall;
  assign dates_stall = in_vld && !res_load;
  assign dates_take  = dates_valid && !dates_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (dates_take) begin
      in_vld <= 1'b1;
    end else if (res_load) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dates_take) begin
      in_from <= '{year: from_year, month: from_month, day: from_day};
      in_to   <= '{year: to_year, month: to_month, day: to_day};
    end
  end

  // years beyond the supported range saturate before any use
  always_comb begin
    from_clamped      = in_from;
    from_clamped.year = dd_pkg::clamp_year(in_from.year);
    to_clamped        = in_to;
    to_clamped.year   = dd_pkg::clamp_year(in_to.year);
  end

  dd_day_number u_from_dn (
    .date       (from_clamped),
    .day_number (from_dn)
  );

  dd_day_number u_to_dn (
    .date       (to_clamped),
    .day_number (to_dn)
  );

  dd_year_count u_years (
    .from_date  (from_clamped),
    .to_date    (to_clamped),
    .full_years (years_calc)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && in_vld) begin
      // day count difference wraps at the field width
      day_difference <= signed'(to_dn - from_dn);
      full_years     <= years_calc;
    end
  end

endmodule

>>> hdl/dd_checker.sv
// dd_checker.sv
// port-level checks for date_difference, bound to the top level
// uses date_difference_assert.svh
`timescale 1ns / 1ps
`include "date_difference_assert.svh"

module dd_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   dates_valid,
  input logic                                   dates_stall,
  input logic                                   result_valid,
  input logic                                   result_stall,
  input logic signed [dd_pkg::DAYNUM_W-1:0]     day_difference,
  input logic signed [dd_pkg::FULL_YEARS_W-1:0] full_years
);

  // a held result word keeps its value
  `DD_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(day_difference) && $stable(full_years), "result word changed while stalled")

  // back pressure on dates comes only from a stalled full result register
  `DD_ASSERT(a_stall_cause, dates_stall |-> result_valid && result_stall, "dates stalled without a stalled result")

  // an accepted word reaches the result register once the way is clear after acceptance
  `DD_ASSERT(a_latency, (dates_valid && !dates_stall) ##1 (!result_valid || !result_stall) |=> result_valid, "accepted word did not reach the result")

  // a fresh result word always traces back to an accepted dates word
  `DD_ASSERT(a_no_phantom, $rose(result_valid) |-> $past(dates_valid && !dates_stall, 2), "result word without a source")

endmodule

bind date_difference dd_checker u_dd_checker (
  .clk            (clk),
  .rst            (rst),
  .dates_valid    (dates_valid),
  .dates_stall    (dates_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .day_difference (day_difference),
  .full_years     (full_years)
);

>>> test/date_difference_tb.sv
// date_difference_tb.sv
// self-checking bench for date_difference: random and corner date pairs, random idling
// depends on dd_pkg and the date_difference rtl
`timescale 1ns / 1ps

module date_difference_tb;

  localparam int RANDOM_PAIRS = 900;
  localparam int QUIET_FROM = 780;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 90;
  localparam int HOLD_OFF_AFTER = 300;

  // expected spans in order of acceptance, with an own day-count model
  class date_span_scoreboard;
    typedef struct {
      dd_pkg::daynum_t     days;
      dd_pkg::full_years_t years;
    } span_t;

    span_t spans_due[$];
    int    accepted;
    int    failures;

    static function bit is_leap(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // years past the top saturate
    function longint year_of(dd_pkg::date_t dt);
      return (dt.year > dd_pkg::YEAR_MAX) ? longint'(dd_pkg::YEAR_MAX) : longint'(dt.year);
    endfunction

    // days before the first of a month; months past december see a full year
    function longint month_start(dd_pkg::month_t m);
      case (m)
        4'd0, 4'd1: return 0;
        4'd2:       return 31;
        4'd3:       return 59;
        4'd4:       return 90;
        4'd5:       return 120;
        4'd6:       return 151;
        4'd7:       return 181;
        4'd8:       return 212;
        4'd9:       return 243;
        4'd10:      return 273;
        4'd11:      return 304;
        4'd12:      return 334;
        default:    return dd_pkg::DAYS_PER_YEAR;
      endcase
    endfunction

    // days counted from the first of year zero
    function longint day_count(dd_pkg::date_t dt);
      longint y;
      longint n;
      y = year_of(dt);
      n = dd_pkg::DAYS_PER_YEAR * y + (y + 3) / 4 - (y + 99) / dd_pkg::CENTURY
          + (y + 399) / dd_pkg::QUAD_CENTURY;
      n += month_start(dt.month) + dt.day;
      if (dt.month > dd_pkg::MONTH_FEB && is_leap(y)) n++;
      return n;
    endfunction

    function void note_dates(dd_pkg::date_t a, dd_pkg::date_t b);
      span_t  s;
      longint yrs;
      s.days = dd_pkg::daynum_t'(day_count(b) - day_count(a));
      yrs = year_of(b) - year_of(a) - 1;
      if (b.month > a.month || (b.month == a.month && b.day >= a.day)) yrs++;
      s.years = dd_pkg::full_years_t'(yrs);
      spans_due.push_back(s);
      accepted++;
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("date_difference tb: %s", what);
    endfunction

    function void check_result(dd_pkg::daynum_t days, dd_pkg::full_years_t years);
      span_t s;
      if (spans_due.size() == 0) begin
        flag($sformatf("result word with nothing outstanding (days %0d years %0d)",
                       $signed(days), years));
        return;
      end
      s = spans_due.pop_front();
      if (days !== s.days)
        flag($sformatf("day_difference got %0d want %0d", $signed(days), $signed(s.days)));
      if (years !== s.years)
        flag($sformatf("full_years got %0d want %0d", years, s.years));
    endfunction

    function int pending();
      return spans_due.size();
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst;
  logic           dates_valid;
  logic           dates_stall;
  dd_pkg::year_t  from_year;
  dd_pkg::month_t from_month;
  dd_pkg::day_t   from_day;
  dd_pkg::year_t  to_year;
  dd_pkg::month_t to_month;
  dd_pkg::day_t   to_day;
  logic           result_valid;
  logic           result_stall;
  logic signed [dd_pkg::DAYNUM_W-1:0]     day_difference;
  logic signed [dd_pkg::FULL_YEARS_W-1:0] full_years;

  date_span_scoreboard sb = new();

  // idling controls shared by both sides; quiet switches all idling off
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          quiet = 1'b0;
  int          cycle_count = 0;

  date_difference dut (
    .clk            (clk),
    .rst            (rst),
    .dates_valid    (dates_valid),
    .dates_stall    (dates_stall),
    .from_year      (from_year),
    .from_month     (from_month),
    .from_day       (from_day),
    .to_year        (to_year),
    .to_month       (to_month),
    .to_day         (to_day),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .day_difference (day_difference),
    .full_years     (full_years)
  );

  always #5 clk = ~clk;

  // watchdog on a runaway or hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // every result word taken at a rising edge is checked against the oldest span
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(day_difference, full_years);
  end

  // receiver: random stall bursts, plus one long hold-off to back the block up
  initial begin
    bit held;
    held = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.accepted >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic dd_pkg::date_t mk(int unsigned y, int unsigned m, int unsigned d);
    dd_pkg::date_t dt;
    dt.year = dd_pkg::year_t'(y);
    dt.month = dd_pkg::month_t'(m);
    dt.day = dd_pkg::day_t'(d);
    return dt;
  endfunction

  // years weighted toward century and leap corners and the saturating range
  function automatic int unsigned pick_year();
    int unsigned corners [11] = '{0, 1, 4, 100, 400, 1600, 1900, 2000, 2100, 9996, 9999};
    case ($urandom_range(0, 9))
      0:       return corners[$urandom_range(0, 10)];
      1:       return $urandom_range(10000, 16383);
      2, 3, 4: return $urandom_range(1900, 2100);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  // a well-formed date, month ends favoured
  function automatic dd_pkg::date_t valid_date(int unsigned y);
    int unsigned m;
    int unsigned len;
    m = $urandom_range(1, 12);
    if (m == 2)
      len = date_span_scoreboard::is_leap(y > dd_pkg::YEAR_MAX ? dd_pkg::YEAR_MAX : y) ? 29 : 28;
    else if (m == 4 || m == 6 || m == 9 || m == 11) len = 30;
    else len = 31;
    return mk(y, m, ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
  endfunction

  function automatic void random_pair(output dd_pkg::date_t a, output dd_pkg::date_t b);
    int unsigned mode;
    int unsigned y;
    mode = $urandom_range(0, 99);
    if (mode < 55) begin
      a = valid_date(pick_year());
      b = valid_date(pick_year());
    end else if (mode < 75) begin
      // near an anniversary: same month and day a few years off, day nudged
      a = valid_date(pick_year());
      b = a;
      b.year = a.year + dd_pkg::year_t'($urandom_range(0, 6)) - dd_pkg::year_t'(3);
      b.day = a.day + dd_pkg::day_t'($urandom_range(0, 2)) - dd_pkg::day_t'(1);
      if ($urandom_range(0, 1)) begin
        b.year = a.year;
        a.year = a.year + dd_pkg::year_t'($urandom_range(0, 6)) - dd_pkg::year_t'(3);
      end
    end else if (mode < 88) begin
      // close dates within a year or two
      y = $urandom_range(1, 9998);
      a = valid_date(y);
      b = valid_date(y + $urandom_range(0, 1));
    end else begin
      // raw bits, invalid months and days included
      a = dd_pkg::date_t'(23'($urandom()));
      b = dd_pkg::date_t'(23'($urandom()));
    end
  endfunction

  // offer one word, hold it until taken, then maybe idle for a burst
  task automatic offer_pair(input dd_pkg::date_t a, input dd_pkg::date_t b);
    dates_valid <= 1'b1;
    from_year <= a.year;
    from_month <= a.month;
    from_day <= a.day;
    to_year <= b.year;
    to_month <= b.month;
    to_day <= b.day;
    do @(posedge clk); while (dates_stall);
    sb.note_dates(a, b);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      dates_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  initial begin
    dd_pkg::date_t a;
    dd_pkg::date_t b;
    rst = 1'b1;
    dates_valid = 1'b0;
    from_year = '0;
    from_month = '0;
    from_day = '0;
    to_year = '0;
    to_month = '0;
    to_day = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct = 30;
    stall_pct = 30;
    // all-zero and all-one fields, both ways round
    offer_pair(mk(0, 0, 0), mk(16383, 15, 31));
    offer_pair(mk(16383, 15, 31), mk(0, 0, 0));
    // widest span from year one to the top year
    offer_pair(mk(1, 1, 1), mk(9999, 12, 31));
    offer_pair(mk(9999, 12, 31), mk(1, 1, 1));
    // years past the top saturate onto the top year
    offer_pair(mk(9999, 1, 1), mk(10000, 1, 1));
    // year zero is a leap year before year one
    offer_pair(mk(0, 1, 1), mk(1, 1, 1));
    offer_pair(mk(0, 3, 1), mk(0, 2, 28));
    // century rules across february
    offer_pair(mk(2000, 2, 28), mk(2000, 3, 1));
    offer_pair(mk(1900, 2, 28), mk(1900, 3, 1));
    offer_pair(mk(2100, 3, 1), mk(2100, 2, 29));
    // leap-day birthdays and the anniversary edge
    offer_pair(mk(2024, 2, 29), mk(2025, 2, 28));
    offer_pair(mk(2024, 2, 29), mk(2028, 2, 29));
    offer_pair(mk(2023, 5, 15), mk(2024, 5, 15));
    offer_pair(mk(2023, 5, 15), mk(2024, 5, 14));
    offer_pair(mk(2024, 5, 15), mk(2023, 5, 16));
    offer_pair(mk(1999, 7, 4), mk(1999, 7, 4));
    // month zero and months past december
    offer_pair(mk(2020, 0, 10), mk(2020, 1, 10));
    offer_pair(mk(2020, 13, 1), mk(2021, 1, 1));
    offer_pair(mk(2021, 15, 0), mk(2021, 14, 31));
    // december against the months around it
    offer_pair(mk(2020, 11, 30), mk(2020, 12, 31));
    offer_pair(mk(2021, 12, 1), mk(2021, 13, 1));
    // day zero and days past the month end
    offer_pair(mk(1999, 4, 31), mk(1999, 5, 1));
    offer_pair(mk(2000, 12, 0), mk(2000, 12, 31));
    // low-bits-set, single-bit and alternating bit patterns
    offer_pair(mk(8191, 8, 16), mk(4096, 7, 8));
    offer_pair(mk(10922, 5, 10), mk(5461, 10, 21));

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 64 == 0) begin
        // switch idling mode now and then so some stretches run flat out
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 45;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 45;
        endcase
      end
      if (n >= QUIET_FROM) quiet = 1'b1;
      random_pair(a, b);
      offer_pair(a, b);
    end
    dates_valid <= 1'b0;

    // drain, then allow for stray words past the pipeline depth
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
